/* hdl/mrrc_pkg.sv */
// Shared constants, types and the CRC-16 table step for the Modbus RTU
// response checker. No dependencies.
package mrrc_pkg;

   localparam int MAX_FRAME = 256;
   localparam int MAX_REGS  = 128;

   localparam int POS_W  = $clog2(MAX_FRAME + 2);
   localparam int ADDR_W = $clog2(MAX_REGS);

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;
   localparam logic [7:0]  EXC_BIT   = 8'h80;
   localparam int          MIN_FRAME = 5;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SHORT = 3'd1,
      ST_CRC   = 3'd2,
      ST_EXC   = 3'd3,
      ST_LEN   = 3'd4
   } status_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      status_type status;
      logic       zero;
   } res_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       data;
   } wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_type;

   // reflected CRC-16 table entry
   function automatic logic [15:0] crc_tab(input logic [7:0] idx);
      logic [15:0] v;
      v = {8'h00, idx};
      for (int b = 0; b < 8; b++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

endpackage

/* hdl/mrrc_if.sv */
// Request and response channel interfaces for the Modbus RTU response checker.
// Valid/ready handshake; no package dependency.
interface mrrc_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;
   logic       frame_end;
   logic [6:0] read_index;

   modport source (output valid, cmd, rx_byte, frame_end, read_index, input ready);
   modport sink   (input valid, cmd, rx_byte, frame_end, read_index, output ready);
endinterface

interface mrrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  status;
   logic [15:0] reg_value;

   modport source (output valid, kind, status, reg_value, input ready);
   modport sink   (input valid, kind, status, reg_value, output ready);
endinterface

/* hdl/mrrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/mrrc_frame.sv */
// Frame tracker: byte window, CRC-16, position decode, word store writes and
// end-of-frame status. Uses mrrc_pkg.
module mrrc_frame import mrrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       cmd,
   input  logic [7:0] rx_byte,
   input  logic       frame_end,
   input  logic [6:0] read_index,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   output res_type    res,
   output wr_type     wr,
   output rd_type     rd
);

   logic [15:0]      crc_ff, crc_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       func_ff, func_in;
   logic [7:0]       count_ff, count_in;
   logic [7:0]       tail0_ff, tail0_in;
   logic [7:0]       tail1_ff, tail1_in;
   logic [7:0]       high_ff, high_in;
   logic [6:0]       expected_ff;

   logic [POS_W-1:0] tp, off;
   logic [31:0]      idx;
   logic             take;
   logic [15:0]      crc_take;
   status_type       st;

   always_comb begin
      crc_in   = crc_ff;
      pos_in   = pos_ff;
      func_in  = func_ff;
      count_in = count_ff;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      high_in  = high_ff;
      wr       = '0;
      rd       = '0;
      res      = '0;
      st       = ST_OK;

      tp       = pos_ff - POS_W'(2);
      off      = tp - POS_W'(3);
      idx      = 32'(off >> 1);
      take     = (pos_ff >= POS_W'(2)) && (pos_ff <= POS_W'(MAX_FRAME));
      crc_take = (crc_ff >> 8) ^ crc_tab(crc_ff[7:0] ^ tail0_ff);

      if (accept && cmd == CMD_READ) begin
         rd.en     = 1'b1;
         rd.addr   = read_index[ADDR_W-1:0];
         res.valid = 1'b1;
         res.kind  = KIND_READ;
         res.zero  = 32'(read_index) >= 32'(MAX_REGS);
      end

      if (accept && cmd == CMD_BYTE) begin
         if (take) begin
            crc_in = crc_take;
            if (tp == POS_W'(1)) begin
               func_in = tail0_ff;
            end else if (tp == POS_W'(2)) begin
               count_in = tail0_ff;
            end else if (tp >= POS_W'(3)) begin
               if (!off[0]) begin
                  high_in = tail0_ff;
               end else if (idx < 32'(MAX_REGS)) begin
                  wr.en   = 1'b1;
                  wr.addr = idx[ADDR_W-1:0];
                  wr.data = {high_ff, tail0_ff};
               end
            end
         end
         tail0_in = tail1_ff;
         tail1_in = rx_byte;
         if (pos_ff <= POS_W'(MAX_FRAME)) begin
            pos_in = pos_ff + POS_W'(1);
         end

         if (frame_end) begin
            if (pos_in < POS_W'(MIN_FRAME)) begin
               st = ST_SHORT;
            end else if (pos_in > POS_W'(MAX_FRAME)) begin
               st = ST_LEN;
            end else if ({rx_byte, tail1_ff} != crc_in) begin
               st = ST_CRC;
            end else if ((func_in & EXC_BIT) != 8'h00) begin
               st = ST_EXC;
            end else if (count_in != {expected_ff, 1'b0}) begin
               st = ST_LEN;
            end
            res.valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = st;
            crc_in     = CRC_INIT;
            pos_in     = '0;
            func_in    = '0;
            count_in   = '0;
            tail0_in   = '0;
            tail1_in   = '0;
            high_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         pos_ff      <= '0;
         func_ff     <= '0;
         count_ff    <= '0;
         tail0_ff    <= '0;
         tail1_ff    <= '0;
         high_ff     <= '0;
         expected_ff <= 7'd1;
      end else begin
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         func_ff  <= func_in;
         count_ff <= count_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
         high_ff  <= high_in;
         if (csr_we) begin
            expected_ff <= csr_wdata;
         end
      end
   end

endmodule

/* hdl/mrrc_out.sv */
// Result stage and output register: pairs result control with RAM read data
// and decouples the response channel. Uses mrrc_pkg.
module mrrc_out import mrrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  res_type     res,
   input  logic [15:0] rd_data,
   input  logic        rsp_ready,
   output logic        req_ready,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_reg_value
);

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kind_ff;
   status_type  s1_status_ff;
   logic        s1_zero_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff;
   logic [2:0]  out_status_ff;
   logic [15:0] out_value_ff;
   logic        move;

   always_comb begin
      move         = s1_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || move;
      s1_valid_in  = res.valid ? 1'b1 : (move ? 1'b0 : s1_valid_ff);
      out_valid_in = move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         s1_kind_ff   <= res.kind;
         s1_status_ff <= res.status;
         s1_zero_ff   <= res.zero;
      end
      if (move) begin
         out_kind_ff   <= s1_kind_ff;
         out_status_ff <= s1_status_ff;
         out_value_ff  <= (s1_kind_ff == KIND_READ && !s1_zero_ff) ? rd_data : 16'h0000;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_reg_value = out_value_ff;

endmodule

/* hdl/modbus_rtu_response_checker.sv */
// Modbus RTU read-holding-registers response checker, top level.
// Results pass the result stage (with the word store read), then the output
// register. Throughput: one request per cycle unless the response channel
// stalls, set by the single read/write port pair of the word store and the
// one-step table CRC. Reset (synchronous): frame state and expected_regs (1)
// reset at once; the word store is not cleared and needs no clearing pass.
module modbus_rtu_response_checker import mrrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mrrc_req_if.sink   req_ch,
   mrrc_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);

   res_type     res;
   wr_type      wr;
   rd_type      rd;
   logic [15:0] rd_data;
   logic        accept;

   assign accept = req_ch.valid && req_ch.ready;

   mrrc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_ch.cmd),
      .rx_byte    (req_ch.rx_byte),
      .frame_end  (req_ch.frame_end),
      .read_index (req_ch.read_index),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .res        (res),
      .wr         (wr),
      .rd         (rd)
   );

   mrrc_ram #(
      .WIDTH (16),
      .DEPTH (MAX_REGS)
   ) u_store (
      .clock (clock),
      .we    (wr.en),
      .waddr (wr.addr),
      .wdata (wr.data),
      .re    (rd.en),
      .raddr (rd.addr),
      .rdata (rd_data)
   );

   mrrc_out u_out (
      .clock         (clock),
      .reset         (reset),
      .res           (res),
      .rd_data       (rd_data),
      .rsp_ready     (rsp_ch.ready),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_kind      (rsp_ch.kind),
      .rsp_status    (rsp_ch.status),
      .rsp_reg_value (rsp_ch.reg_value)
   );

endmodule

/* hdl/mrrc_checker.sv */
// Port-level assertions for the Modbus RTU response checker, with the bind
// that attaches them to the top level. Uses mrrc_pkg.
module mrrc_checker import mrrc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_reg_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_status_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_reg_value == 16'h0000)
      else $error("status response carries a register value");

   a_read_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_READ |-> rsp_status == 3'(ST_OK))
      else $error("read response carries a status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'(ST_LEN))
      else $error("status code out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind modbus_rtu_response_checker mrrc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_kind      (rsp_ch.kind),
   .rsp_status    (rsp_ch.status),
   .rsp_reg_value (rsp_ch.reg_value)
);

/* tb/sv/modbus_rtu_response_checker_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU response checker: directed frames from a table,
// then random frames, reads and noise, checked against a frame-state and word-store predictor.
// Depends on mrrc_pkg, mrrc_req_if / mrrc_rsp_if and modbus_rtu_response_checker.
module modbus_rtu_response_checker_tb;
   import mrrc_pkg::*;

   localparam int RSP_LATENCY  = 2;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 200;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
      logic       frame_end;
      logic [6:0] read_index;
   } request_type;

   typedef struct packed {
      logic        kind;
      status_type  status;
      logic [15:0] reg_value;
   } response_type;

   typedef enum {ROW_CFG, ROW_FRAME, ROW_RAW, ROW_READ} row_op_type;

   typedef struct {
      row_op_type op;
      int         arg;
      logic [7:0] func;
      bit         bad_crc;
      bit         typed;
      status_type st;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [6:0] csr_wdata;

   mrrc_req_if req_ch ();
   mrrc_rsp_if rsp_ch ();

   modbus_rtu_response_checker u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [15:0] pr_crc;
   int unsigned pr_pos;
   logic [7:0]  pr_func;
   logic [7:0]  pr_count;
   logic [7:0]  pr_hi;
   logic [7:0]  pr_win [0:1];
   logic [15:0] pr_words [0:MAX_REGS-1];
   bit          pr_written [0:MAX_REGS-1];
   int          written_list [$];
   logic [6:0]  pr_exp_regs;

   response_type   expected_responses [$];
   response_type   want;
   logic [7:0]     frame_q [$];
   plan_row_type   plan [$];

   int  errors = 0;
   int  items_sent = 0;
   int  reads_seen = 0;
   int  cfg_writes = 0;
   int  holds_done = 0;
   int  status_count [0:7];
   int  burst_left = 0;
   bit  calm = 0;
   bit  req_live = 0;
   bit  hold_off = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] v;
      v = c ^ {8'h00, d};
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
      end
      return v;
   endfunction

   function automatic void clear_frame();
      pr_crc    = CRC_INIT;
      pr_pos    = 0;
      pr_func   = 8'h00;
      pr_count  = 8'h00;
      pr_hi     = 8'h00;
      pr_win[0] = 8'h00;
      pr_win[1] = 8'h00;
   endfunction

   function automatic void absorb_byte(input int unsigned p, input logic [7:0] d);
      int unsigned off;
      int unsigned idx;
      pr_crc = crc16_step(pr_crc, d);
      if (p == 1) begin
         pr_func = d;
      end else if (p == 2) begin
         pr_count = d;
      end else if (p >= 3) begin
         off = p - 3;
         if (off % 2 == 0) begin
            pr_hi = d;
         end else begin
            idx = off / 2;
            if (idx < MAX_REGS) begin
               pr_words[idx] = {pr_hi, d};
               if (!pr_written[idx]) begin
                  pr_written[idx] = 1'b1;
                  written_list.push_back(idx);
               end
            end
         end
      end
   endfunction

   function automatic void predict_response(input request_type r, output bit has_rsp,
                                            output response_type rsp);
      int unsigned len;
      logic [15:0] tail_crc;
      rsp     = '0;
      has_rsp = 1'b0;
      if (r.cmd == CMD_READ) begin
         has_rsp       = 1'b1;
         rsp.kind      = KIND_READ;
         rsp.status    = ST_OK;
         rsp.reg_value = (r.read_index < MAX_REGS) ? pr_words[r.read_index] : 16'h0000;
         return;
      end
      if (pr_pos >= 2 && pr_pos <= MAX_FRAME) absorb_byte(pr_pos - 2, pr_win[0]);
      pr_win[0] = pr_win[1];
      pr_win[1] = r.rx_byte;
      if (pr_pos <= MAX_FRAME) pr_pos++;
      if (!r.frame_end) return;
      len      = pr_pos;
      tail_crc = {pr_win[1], pr_win[0]};
      has_rsp  = 1'b1;
      rsp.kind = KIND_STATUS;
      if (len < MIN_FRAME) rsp.status = ST_SHORT;
      else if (len > MAX_FRAME) rsp.status = ST_LEN;
      else if (tail_crc != pr_crc) rsp.status = ST_CRC;
      else if ((pr_func & EXC_BIT) != 8'h00) rsp.status = ST_EXC;
      else if (pr_count != {pr_exp_regs, 1'b0}) rsp.status = ST_LEN;
      else rsp.status = ST_OK;
      clear_frame();
   endfunction

   function automatic void build_frame(input int nw, input logic [7:0] func,
                                       input logic [7:0] count, input bit bad_crc);
      logic [15:0] c;
      frame_q.delete();
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(func);
      frame_q.push_back(count);
      for (int i = 0; i < 2 * nw; i++) frame_q.push_back(8'($urandom_range(0, 255)));
      c = CRC_INIT;
      foreach (frame_q[i]) c = crc16_step(c, frame_q[i]);
      if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
   endfunction

   function automatic void build_raw(input int n, input bit with_crc);
      logic [15:0] c;
      frame_q.delete();
      for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom_range(0, 255)));
      if (with_crc && n >= 3) begin
         c = CRC_INIT;
         for (int i = 0; i < n - 2; i++) c = crc16_step(c, frame_q[i]);
         frame_q[n-2] = c[7:0];
         frame_q[n-1] = c[15:8];
      end
   endfunction

   function automatic void add_row(input row_op_type op, input int arg, input logic [7:0] func,
                                   input bit bad_crc, input bit typed, input status_type st);
      plan_row_type row;
      row.op      = op;
      row.arg     = arg;
      row.func    = func;
      row.bad_crc = bad_crc;
      row.typed   = typed;
      row.st      = st;
      plan.push_back(row);
   endfunction

   task automatic idle_gap(input int n);
      req_ch.valid <= 1'b0;
      req_live = 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic pace();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) idle_gap(gap);
      end
   endtask

   task automatic offer(input request_type r, input bit typed, input status_type typed_st);
      bit has_rsp;
      response_type rsp;
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= r.cmd;
      req_ch.rx_byte    <= r.rx_byte;
      req_ch.frame_end  <= r.frame_end;
      req_ch.read_index <= r.read_index;
      req_live = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_response(r, has_rsp, rsp);
      if (has_rsp) begin
         if (typed) begin
            rsp.kind      = KIND_STATUS;
            rsp.status    = typed_st;
            rsp.reg_value = 16'h0000;
         end
         expected_responses.push_back(rsp);
      end
      items_sent++;
      pace();
   endtask

   task automatic drain();
      if (req_live) idle_gap(1);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_expected_regs(input logic [6:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      pr_exp_regs = v;
      cfg_writes++;
      @(posedge clock);
   endtask

   task automatic send_frame(input bit typed, input status_type st);
      request_type r;
      foreach (frame_q[i]) begin
         r.cmd        = CMD_BYTE;
         r.rx_byte    = frame_q[i];
         r.frame_end  = (i == frame_q.size() - 1);
         r.read_index = 7'($urandom_range(0, 127));
         offer(r, typed && r.frame_end, st);
      end
   endtask

   task automatic send_read_at(input int idx);
      request_type r;
      r.cmd        = CMD_READ;
      r.rx_byte    = 8'($urandom_range(0, 255));
      r.frame_end  = 1'($urandom_range(0, 1));
      r.read_index = 7'(idx);
      offer(r, 1'b0, ST_OK);
   endtask

   task automatic send_read();
      if (written_list.size() == 0) return;
      send_read_at(written_list[$urandom_range(0, written_list.size() - 1)]);
   endtask

   task automatic send_noise();
      request_type r;
      int n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         r.cmd        = CMD_BYTE;
         r.rx_byte    = 8'($urandom_range(0, 255));
         r.frame_end  = (i == n - 1) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 15) == 0);
         r.read_index = 7'($urandom_range(0, 127));
         offer(r, 1'b0, ST_OK);
      end
   endtask

   task automatic close_frame();
      request_type r;
      if (pr_pos == 0) return;
      r.cmd        = CMD_BYTE;
      r.rx_byte    = 8'($urandom_range(0, 255));
      r.frame_end  = 1'b1;
      r.read_index = 7'($urandom_range(0, 127));
      offer(r, 1'b0, ST_OK);
   endtask

   task automatic send_random_frame();
      int pick;
      int nw;
      logic [7:0] func;
      logic [7:0] count;
      bit bad;
      pick = $urandom_range(0, 99);
      nw   = (pr_exp_regs <= 16 || $urandom_range(0, 3) == 0) ? pr_exp_regs
                                                               : $urandom_range(1, 8);
      func  = 8'h03;
      count = 8'(2 * nw);
      bad   = 1'b0;
      if (pick < 55) begin
      end else if (pick < 65) begin
         func  = 8'($urandom_range(0, 255)) | EXC_BIT;
         nw    = 0;
         count = 8'($urandom_range(0, 255));
      end else if (pick < 75) begin
         bad = 1'b1;
      end else if (pick < 83) begin
         count = {pr_exp_regs, 1'b0} ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick < 87) begin
         func = 8'($urandom_range(0, 255)) & ~EXC_BIT;
      end else if (pick < 92) begin
         build_raw($urandom_range(1, 4), 1'b1);
         send_frame(1'b0, ST_OK);
         return;
      end else if (pick < 94) begin
         build_raw($urandom_range(MAX_FRAME + 1, MAX_FRAME + 24), 1'b1);
         send_frame(1'b0, ST_OK);
         return;
      end else begin
         send_noise();
         return;
      end
      build_frame(nw, func, count, bad);
      send_frame(1'b0, ST_OK);
   endtask

   task automatic squeeze_responses();
      bit was_calm;
      was_calm = calm;
      calm     = 1'b1;
      hold_off = 1'b1;
      repeat (64) send_read();
      calm = was_calm;
      drain();
   endtask

   // receiver: random ready pattern, with a long hold-off on demand
   initial begin : rsp_pattern
      int mode;
      int left;
      int tick;
      logic rdy;
      rsp_ch.ready <= 1'b0;
      mode = 0;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
            holds_done++;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(32, 256);
            end
            left--;
            tick++;
            case (mode)
               0: rdy = 1'b1;
               1: rdy = ($urandom_range(0, 3) != 0);
               2: rdy = ($urandom_range(0, 3) == 0);
               default: rdy = ((tick % 7) < 4);
            endcase
            rsp_ch.ready <= rdy;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_responses.size() == 0) begin
            $display("%0t: response with none expected, actual kind %0d status %0d value %h",
                     $time, rsp_ch.kind, rsp_ch.status, rsp_ch.reg_value);
            errors++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_ch.kind !== want.kind) begin
               $display("%0t: kind mismatch, expected %0d, actual %0d",
                        $time, want.kind, rsp_ch.kind);
               errors++;
            end
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.reg_value !== want.reg_value) begin
               $display("%0t: reg_value mismatch, expected %h, actual %h",
                        $time, want.reg_value, rsp_ch.reg_value);
               errors++;
            end
            if (want.kind == KIND_READ) reads_seen++;
            else status_count[want.status]++;
         end
      end
   end

   initial begin : stimulus
      int random_start;
      int phase_left;
      int phase_no;
      int pick;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= 7'd0;
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= CMD_BYTE;
      req_ch.rx_byte    <= 8'h00;
      req_ch.frame_end  <= 1'b0;
      req_ch.read_index <= 7'd0;
      foreach (status_count[i]) status_count[i] = 0;
      foreach (pr_written[i]) pr_written[i] = 1'b0;
      foreach (pr_words[i]) pr_words[i] = 16'h0000;
      clear_frame();
      pr_exp_regs = 7'd1;

      add_row(ROW_FRAME, 1,   8'h03, 0, 1, ST_OK);
      add_row(ROW_READ,  0,   8'h00, 0, 0, ST_OK);
      add_row(ROW_RAW,   1,   8'h00, 1, 1, ST_SHORT);
      add_row(ROW_RAW,   4,   8'h00, 1, 1, ST_SHORT);
      add_row(ROW_FRAME, 0,   8'h83, 0, 1, ST_EXC);
      add_row(ROW_FRAME, 1,   8'h03, 1, 1, ST_CRC);
      add_row(ROW_FRAME, 2,   8'h03, 0, 1, ST_LEN);
      add_row(ROW_CFG,   125, 8'h00, 0, 0, ST_OK);
      add_row(ROW_FRAME, 125, 8'h03, 0, 1, ST_OK);
      add_row(ROW_READ,  124, 8'h00, 0, 0, ST_OK);
      add_row(ROW_READ,  0,   8'h00, 0, 0, ST_OK);
      add_row(ROW_READ,  64,  8'h00, 0, 0, ST_OK);
      add_row(ROW_RAW,   270, 8'h00, 1, 1, ST_LEN);
      add_row(ROW_RAW,   256, 8'h00, 0, 0, ST_OK);
      add_row(ROW_CFG,   0,   8'h00, 0, 0, ST_OK);
      add_row(ROW_FRAME, 0,   8'h03, 0, 1, ST_OK);
      add_row(ROW_FRAME, 0,   8'h83, 0, 1, ST_EXC);
      add_row(ROW_CFG,   127, 8'h00, 0, 0, ST_OK);
      add_row(ROW_FRAME, 3,   8'h03, 0, 1, ST_LEN);
      add_row(ROW_FRAME, 2,   8'hFF, 1, 1, ST_CRC);
      add_row(ROW_CFG,   1,   8'h00, 0, 0, ST_OK);
      add_row(ROW_READ,  1,   8'h00, 0, 0, ST_OK);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         case (plan[k].op)
            ROW_CFG: write_expected_regs(7'(plan[k].arg));
            ROW_FRAME: begin
               build_frame(plan[k].arg, plan[k].func, 8'(2 * plan[k].arg), plan[k].bad_crc);
               send_frame(plan[k].typed, plan[k].st);
            end
            ROW_RAW: begin
               build_raw(plan[k].arg, !plan[k].bad_crc);
               send_frame(plan[k].typed, plan[k].st);
            end
            default: send_read_at(plan[k].arg);
         endcase
      end

      squeeze_responses();

      random_start = items_sent;
      phase_left   = 0;
      phase_no     = 0;
      while (items_sent < random_start + RANDOM_ITEMS) begin
         if (phase_left <= 0) begin
            close_frame();
            pick = $urandom_range(0, 99);
            if (pick < 70) write_expected_regs(7'($urandom_range(1, 8)));
            else if (pick < 78) write_expected_regs(7'd0);
            else if (pick < 86) write_expected_regs(7'd125);
            else if (pick < 90) write_expected_regs(7'd127);
            else write_expected_regs(7'($urandom_range(0, 127)));
            calm       = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(80, 200);
            phase_no++;
            if (phase_no == 4) squeeze_responses();
         end
         pick = items_sent;
         if ($urandom_range(0, 9) == 0) send_read();
         else send_random_frame();
         repeat ($urandom_range(0, 3)) send_read();
         phase_left -= items_sent - pick;
      end

      drain();
      $display("Sent %0d requests; %0d reads and %0d frame statuses returned", items_sent,
               reads_seen, status_count[ST_OK] + status_count[ST_SHORT] + status_count[ST_CRC]
               + status_count[ST_EXC] + status_count[ST_LEN]);
      $display("ok %0d short %0d crc %0d exception %0d length %0d; %0d settings, %0d hold-offs",
               status_count[ST_OK], status_count[ST_SHORT], status_count[ST_CRC],
               status_count[ST_EXC], status_count[ST_LEN], cfg_writes, holds_done);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
